>>> design/mer_pkg.sv
// Shared types, widths and codes for the midpoint ellipse rasterizer.
package mer_pkg;

  localparam int DEF_COORD_BITS = 12;
  localparam int RADIUS_BITS    = 11;
  localparam int OUT_W          = 14;
  localparam int IN_DATA_W      = 8;
  localparam int OUT_DATA_W     = 4 * OUT_W;
  localparam int CFG_ADDR_W     = 2;

  localparam int SQ_W    = 2 * RADIUS_BITS;       // a*a, b*b
  localparam int OFFX_W  = RADIUS_BITS + 2;       // x offset, headroom past a
  localparam int OFFY_W  = RADIUS_BITS + 1;       // y offset, signed, ends at -1
  localparam int SLOPE_W = 38;                    // signed slope terms
  localparam int TERM_W  = SLOPE_W + 1;
  localparam int DEC_W   = 52;                    // signed decision value (x4)
  localparam int TMP_W   = DEC_W - 1;             // unsigned crossover partials
  localparam int TX_W    = OFFX_W + 1;            // 2x+1
  localparam int TX2_W   = 2 * TX_W;
  localparam int MUL_W   = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS_B = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ONE,
    PH_TWO,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP_A2,
    ST_SETUP_B2,
    ST_SETUP_AB,
    ST_SETUP_DEC,
    ST_CROSS_TX,
    ST_CROSS_TY,
    ST_CROSS_BT,
    ST_CROSS_AU,
    ST_CROSS_AB,
    ST_CROSS_DEC,
    ST_EMIT,
    ST_TERM,
    ST_DEC_UPD
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SETUP_A2,
    OP_SETUP_B2,
    OP_SETUP_AB,
    OP_SETUP_DEC,
    OP_CROSS_TX,
    OP_CROSS_TY,
    OP_CROSS_BT,
    OP_CROSS_AU,
    OP_CROSS_AB,
    OP_CROSS_DEC,
    OP_EMIT,
    OP_TERM,
    OP_DEC_UPD
  } op_t;

  typedef enum logic [1:0] {
    UPD_R1_NEG,
    UPD_R1_POS,
    UPD_R2_POS,
    UPD_R2_NEG
  } upd_t;

  typedef struct packed {
    op_t    op;
    phase_t phase;
  } cmd_t;

  typedef struct packed {
    logic sx_lt_sy;
    logic y_le_zero;
  } status_t;

endpackage

>>> design/mer_ctrl.sv
// Sequencer for the ellipse rasterizer: item handshake, phase and datapath commands.
module mer_ctrl import mer_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_start,
  output logic    in_tready,
  input  logic    out_tready,
  output logic    out_tvalid,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd.op        = OP_NONE;
    cmd.phase     = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_start) begin
            phase_nxt = PH_ONE;
            state_nxt = ST_SETUP_A2;
          end else if (phase_r == PH_ONE && !status.sx_lt_sy) begin
            phase_nxt = PH_TWO;
            state_nxt = ST_CROSS_TX;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_SETUP_A2: begin
        cmd.op    = OP_SETUP_A2;
        state_nxt = ST_SETUP_B2;
      end
      ST_SETUP_B2: begin
        cmd.op    = OP_SETUP_B2;
        state_nxt = ST_SETUP_AB;
      end
      ST_SETUP_AB: begin
        cmd.op    = OP_SETUP_AB;
        state_nxt = ST_SETUP_DEC;
      end
      ST_SETUP_DEC: begin
        cmd.op = OP_SETUP_DEC;
        // slopes are settled here; a flat ellipse skips region one at once
        if (!status.sx_lt_sy) begin
          phase_nxt = PH_TWO;
          state_nxt = ST_CROSS_TX;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_CROSS_TX: begin
        cmd.op    = OP_CROSS_TX;
        state_nxt = ST_CROSS_TY;
      end
      ST_CROSS_TY: begin
        cmd.op    = OP_CROSS_TY;
        state_nxt = ST_CROSS_BT;
      end
      ST_CROSS_BT: begin
        cmd.op    = OP_CROSS_BT;
        state_nxt = ST_CROSS_AU;
      end
      ST_CROSS_AU: begin
        cmd.op    = OP_CROSS_AU;
        state_nxt = ST_CROSS_AB;
      end
      ST_CROSS_AB: begin
        cmd.op    = OP_CROSS_AB;
        state_nxt = ST_CROSS_DEC;
      end
      ST_CROSS_DEC: begin
        cmd.op    = OP_CROSS_DEC;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          if (phase_r == PH_ONE || phase_r == PH_TWO) begin
            state_nxt = ST_TERM;
            if (phase_r == PH_TWO && status.y_le_zero) begin
              phase_nxt = PH_DONE;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TERM: begin
        cmd.op    = OP_TERM;
        state_nxt = ST_DEC_UPD;
      end
      ST_DEC_UPD: begin
        cmd.op    = OP_DEC_UPD;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_start_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_start) |=> (state_r == ST_SETUP_A2 && phase_r == PH_ONE))
    else $error("start item did not enter setup in region one");

  a_cross_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CROSS_TX) |-> (phase_r == PH_TWO))
    else $error("crossover setup outside region two");

  a_no_skip_two: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ONE) |=> (phase_r != PH_DONE))
    else $error("ellipse finished without passing region two");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !out_valid_r) |=> out_valid_r)
    else $error("result not loaded while output register was empty");
`endif

endmodule

>>> design/mer_datapath.sv
// Datapath of the ellipse rasterizer: config registers, shared multiplier, iteration state.
module mer_datapath import mer_pkg::*; #(
  parameter  int COORD_BITS = DEF_COORD_BITS,
  localparam int CFG_W      = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_live,
  output logic                  out_last
);

  localparam int SUM_W = ((COORD_BITS > OFFY_W) ? COORD_BITS : OFFY_W) + 2;

  // configuration
  logic [COORD_BITS-1:0]  cx_r, cy_r;
  logic [RADIUS_BITS-1:0] ra_r, rb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      ra_r <= '0;
      rb_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CENTER_X: cx_r <= cfg_wdata[COORD_BITS-1:0];
        CFG_CENTER_Y: cy_r <= cfg_wdata[COORD_BITS-1:0];
        CFG_RADIUS_A: ra_r <= cfg_wdata[RADIUS_BITS-1:0];
        CFG_RADIUS_B: rb_r <= cfg_wdata[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // working state
  logic [COORD_BITS-1:0]    lat_cx_r, lat_cx_nxt, lat_cy_r, lat_cy_nxt;
  logic [RADIUS_BITS-1:0]   lat_b_r, lat_b_nxt;
  logic [SQ_W-1:0]          a2_r, a2_nxt, b2_r, b2_nxt;
  logic [OFFX_W-1:0]        off_x_r, off_x_nxt;
  logic signed [OFFY_W-1:0] off_y_r, off_y_nxt;
  logic signed [SLOPE_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [DEC_W-1:0]  dec_r, dec_nxt;
  logic [TMP_W-1:0]         tmp1_r, tmp1_nxt, tmp2_r, tmp2_nxt, tmp3_r, tmp3_nxt;
  logic signed [TERM_W-1:0] term_r, term_nxt;
  upd_t                     kind_r, kind_nxt;
  logic [OUT_DATA_W-1:0]    out_data_r, out_data_nxt;
  logic                     out_live_r, out_live_nxt, out_last_r, out_last_nxt;

  // shared multiplier
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [2*MUL_W-1:0]   mul_p;
  logic [TX_W-1:0]      tx;
  logic [OFFY_W-1:0]    ty_full;
  logic [RADIUS_BITS-1:0] ty_mag;

  assign tx      = {off_x_r, 1'b1};
  assign ty_full = off_y_r - OFFY_W'(1);
  // y is never below zero at the crossover; y-1 = -1 squares to 1
  assign ty_mag  = (off_y_r == '0) ? RADIUS_BITS'(1) : ty_full[RADIUS_BITS-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SETUP_A2: begin
        mul_a = MUL_W'(ra_r);
        mul_b = MUL_W'(ra_r);
      end
      OP_SETUP_B2: begin
        mul_a = MUL_W'(lat_b_r);
        mul_b = MUL_W'(lat_b_r);
      end
      OP_SETUP_AB: begin
        mul_a = MUL_W'(a2_r);
        mul_b = MUL_W'(lat_b_r);
      end
      OP_CROSS_TX: begin
        mul_a = MUL_W'(tx);
        mul_b = MUL_W'(tx);
      end
      OP_CROSS_TY: begin
        mul_a = MUL_W'(ty_mag);
        mul_b = MUL_W'(ty_mag);
      end
      OP_CROSS_BT: begin
        mul_a = MUL_W'(b2_r);
        mul_b = MUL_W'(tmp1_r[TX2_W-1:0]);
      end
      OP_CROSS_AU: begin
        mul_a = MUL_W'(a2_r);
        mul_b = MUL_W'(tmp2_r[SQ_W-1:0]);
      end
      OP_CROSS_AB: begin
        mul_a = MUL_W'(a2_r);
        mul_b = MUL_W'(b2_r);
      end
      default: ;
    endcase
  end

  assign mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

  // extended operands
  logic signed [DEC_W-1:0]   a2_d, b2_d, sy_d;
  logic signed [SLOPE_W-1:0] a2x2, b2x2;
  logic signed [TERM_W-1:0]  t_sx, t_sy, t_sq;
  logic [SUM_W-1:0]          cx_s, cy_s, ox_s, oy_s;
  logic [SUM_W-1:0]          ppx, ppy, pnx, pny;
  logic                      live, y_le0;

  assign a2_d = $signed(DEC_W'(a2_r));
  assign b2_d = $signed(DEC_W'(b2_r));
  assign sy_d = DEC_W'(sy_r);
  assign a2x2 = $signed(SLOPE_W'({a2_r, 1'b0}));
  assign b2x2 = $signed(SLOPE_W'({b2_r, 1'b0}));

  assign t_sx = (kind_r == UPD_R2_POS) ? '0 : TERM_W'(sx_r);
  assign t_sy = (kind_r == UPD_R1_NEG) ? '0 : TERM_W'(sy_r);
  assign t_sq = (kind_r == UPD_R1_NEG || kind_r == UPD_R1_POS) ?
                $signed(TERM_W'(b2_r)) : $signed(TERM_W'(a2_r));

  assign cx_s = SUM_W'(lat_cx_r);
  assign cy_s = SUM_W'(lat_cy_r);
  assign ox_s = SUM_W'(off_x_r);
  assign oy_s = SUM_W'(off_y_r);
  assign ppx  = cx_s + ox_s;
  assign ppy  = cy_s + oy_s;
  assign pnx  = cx_s - ox_s;
  assign pny  = cy_s - oy_s;

  assign live  = (cmd.phase == PH_ONE) || (cmd.phase == PH_TWO);
  assign y_le0 = (off_y_r <= 0);

  always_comb begin
    lat_cx_nxt   = lat_cx_r;
    lat_cy_nxt   = lat_cy_r;
    lat_b_nxt    = lat_b_r;
    a2_nxt       = a2_r;
    b2_nxt       = b2_r;
    off_x_nxt    = off_x_r;
    off_y_nxt    = off_y_r;
    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    dec_nxt      = dec_r;
    tmp1_nxt     = tmp1_r;
    tmp2_nxt     = tmp2_r;
    tmp3_nxt     = tmp3_r;
    term_nxt     = term_r;
    kind_nxt     = kind_r;
    out_data_nxt = out_data_r;
    out_live_nxt = out_live_r;
    out_last_nxt = out_last_r;
    unique case (cmd.op)
      OP_SETUP_A2: begin
        lat_cx_nxt = cx_r;
        lat_cy_nxt = cy_r;
        lat_b_nxt  = rb_r;
        a2_nxt     = mul_p[SQ_W-1:0];
        off_x_nxt  = '0;
        off_y_nxt  = $signed(OFFY_W'(rb_r));
        sx_nxt     = '0;
      end
      OP_SETUP_B2: b2_nxt = mul_p[SQ_W-1:0];
      OP_SETUP_AB: sy_nxt = $signed({mul_p[SLOPE_W-2:0], 1'b0});
      // 4*b^2 - 4*a^2*b + a^2, with slope_y = 2*a^2*b
      OP_SETUP_DEC: dec_nxt = (b2_d <<< 2) - (sy_d <<< 1) + a2_d;
      OP_CROSS_TX:  tmp1_nxt = mul_p[TMP_W-1:0];
      OP_CROSS_TY:  tmp2_nxt = mul_p[TMP_W-1:0];
      OP_CROSS_BT:  tmp1_nxt = mul_p[TMP_W-1:0];
      OP_CROSS_AU:  tmp2_nxt = mul_p[TMP_W-1:0];
      OP_CROSS_AB:  tmp3_nxt = mul_p[TMP_W-1:0];
      OP_CROSS_DEC: begin
        dec_nxt = $signed(DEC_W'(tmp1_r)) + ($signed(DEC_W'(tmp2_r)) <<< 2)
                - ($signed(DEC_W'(tmp3_r)) <<< 2);
      end
      OP_EMIT: begin
        out_live_nxt = live;
        out_last_nxt = live && (cmd.phase == PH_TWO) && y_le0;
        out_data_nxt = live ? {pny[OUT_W-1:0], pnx[OUT_W-1:0],
                               ppy[OUT_W-1:0], ppx[OUT_W-1:0]} : '0;
        if (cmd.phase == PH_ONE) begin
          off_x_nxt = off_x_r + OFFX_W'(1);
          sx_nxt    = sx_r + b2x2;
          if (dec_r < 0) begin
            kind_nxt = UPD_R1_NEG;
          end else begin
            kind_nxt  = UPD_R1_POS;
            off_y_nxt = off_y_r - OFFY_W'(1);
            sy_nxt    = sy_r - a2x2;
          end
        end else if (cmd.phase == PH_TWO) begin
          off_y_nxt = off_y_r - OFFY_W'(1);
          sy_nxt    = sy_r - a2x2;
          if (dec_r > 0) begin
            kind_nxt = UPD_R2_POS;
          end else begin
            kind_nxt  = UPD_R2_NEG;
            off_x_nxt = off_x_r + OFFX_W'(1);
            sx_nxt    = sx_r + b2x2;
          end
        end
      end
      OP_TERM:    term_nxt = t_sx - t_sy + t_sq;
      OP_DEC_UPD: dec_nxt  = dec_r + (DEC_W'(term_r) <<< 2);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    lat_cx_r   <= lat_cx_nxt;
    lat_cy_r   <= lat_cy_nxt;
    lat_b_r    <= lat_b_nxt;
    a2_r       <= a2_nxt;
    b2_r       <= b2_nxt;
    off_x_r    <= off_x_nxt;
    off_y_r    <= off_y_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    dec_r      <= dec_nxt;
    tmp1_r     <= tmp1_nxt;
    tmp2_r     <= tmp2_nxt;
    tmp3_r     <= tmp3_nxt;
    term_r     <= term_nxt;
    kind_r     <= kind_nxt;
    out_data_r <= out_data_nxt;
    out_live_r <= out_live_nxt;
    out_last_r <= out_last_nxt;
  end

  assign status.sx_lt_sy  = (sx_r < sy_r);
  assign status.y_le_zero = y_le0;
  assign out_data = out_data_r;
  assign out_live = out_live_r;
  assign out_last = out_last_r;

endmodule

>>> design/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer: controller plus datapath.
//
// Usage:
//  - Write center_x (index 0), center_y (1), radius_a (2) and radius_b (3) on the
//    cfg_ port while idle; a write lands at the clock edge with cfg_we high.
//  - Each input item (in_tdata bit 0 = start_req) yields exactly one output item.
//    start_req=1 latches the registers and begins a new ellipse; 0 advances one
//    iteration. out_tdata carries the four mirrored coordinates, out_tuser marks
//    a live iteration, out_tlast marks the final one. Past the end, or before any
//    start, items come back with all fields zero.
//  - From accept to out_tvalid a plain step goes straight to emit, a start item
//    first passes the setup states (A2, B2, AB, DEC), and a step that crosses from
//    region one into region two first passes the crossover states (TX to DEC).
//  - A live step then runs the term and decision-update steps, and only back in
//    idle is a new item accepted. The setup and crossover products run one at a time
//    through a single 32x32 multiplier; the per-step update is adds only.
//  - A stalled receiver holds the result in the output register; the next item
//    is still accepted and worked on, and waits at the emit step for the slot.
//  - Synchronous active-low reset clears the configuration to zero, empties the
//    output register and returns to idle with no ellipse in progress.
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter  int COORD_BITS = DEF_COORD_BITS,
  localparam int CFG_W      = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] start_req, [7:1] zero
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [13:0] px_pos_x, [27:14] py_pos_y,
                                            // [41:28] px_neg_x, [55:42] py_neg_y
  output logic                  out_tuser,  // [0] points_valid
  output logic                  out_tlast,  // last_points
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  // sequencing, handshakes and ellipse phase
  mer_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_start   (in_tdata[0]),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .status     (status),
    .cmd        (cmd)
  );

  // arithmetic, configuration and the output payload register
  mer_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_tdata),
    .out_live  (out_tuser),
    .out_last  (out_tlast)
  );

endmodule
